// ===== sv/websocket_frame_deframer_defines.svh =====
// Assertion macros used by the checker file of the frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== sv/wsd_pkg.sv =====
// Shared types and constants of the frame deframer.
`default_nettype none

package wsd_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = $clog2(QDepth);

	localparam logic [15:0] MaxPayloadReset = 16'd4096;
	localparam logic [6:0]  Len16Code       = 7'd126;
	localparam logic [6:0]  Len64Code       = 7'd127;
	localparam logic [2:0]  Ext16Bytes      = 3'd1;
	localparam logic [2:0]  Ext64Bytes      = 3'd7;

	// register index codes
	localparam logic RegMaxPayload = 1'b0;

	// result kind codes
	localparam logic KindHeader  = 1'b0;
	localparam logic KindPayload = 1'b1;

	typedef enum logic [4:0] {
		PH_BYTE0 = 5'b00001,
		PH_BYTE1 = 5'b00010,
		PH_EXT   = 5'b00100,
		PH_KEY   = 5'b01000,
		PH_DATA  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic        item_kind;
		logic        fin_bit;
		logic [3:0]  frame_opcode;
		logic        is_masked;
		logic [62:0] payload_len;
		logic        oversize;
		logic [7:0]  data_byte;
		logic        last;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== sv/wsd_front.sv =====
// Front end: header parser and payload unmasker, one byte per cycle while accept is high.
`default_nettype none

module wsd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      rx_byte,
	input  wire logic [15:0]     max_payload,
	output logic                 push,
	output wsd_pkg::res_t        push_item
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  ext_q, ext_d;
	logic [62:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kc_q, kc_d;
	logic [62:0] left_q, left_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic        masked_q, masked_d;

	logic        emit;
	logic        len_done;
	logic        hdr_done;
	logic [7:0]  kb;
	logic        data_last;

	always_comb begin
		unique case (kc_q)
			2'd0: kb = key_q[31:24];
			2'd1: kb = key_q[23:16];
			2'd2: kb = key_q[15:8];
			2'd3: kb = key_q[7:0];
			default: kb = key_q[31:24];
		endcase
	end

	assign data_last = (left_q[62:1] == 62'd0);

	always_comb begin
		phase_d   = phase_q;
		ext_d     = ext_q;
		len_d     = len_q;
		key_d     = key_q;
		kc_d      = kc_q;
		left_d    = left_q;
		fin_d     = fin_q;
		op_d      = op_q;
		masked_d  = masked_q;
		emit      = 1'b0;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		push_item = '0;

		unique case (phase_q)
			wsd_pkg::PH_BYTE0: begin
				fin_d   = rx_byte[7];
				op_d    = rx_byte[3:0];
				phase_d = wsd_pkg::PH_BYTE1;
			end
			wsd_pkg::PH_BYTE1: begin
				masked_d = rx_byte[7];
				key_d    = '0;
				len_d    = '0;
				if (rx_byte[6:0] == wsd_pkg::Len16Code) begin
					ext_d   = wsd_pkg::Ext16Bytes;
					phase_d = wsd_pkg::PH_EXT;
				end else if (rx_byte[6:0] == wsd_pkg::Len64Code) begin
					ext_d   = wsd_pkg::Ext64Bytes;
					phase_d = wsd_pkg::PH_EXT;
				end else begin
					len_d    = {56'd0, rx_byte[6:0]};
					len_done = 1'b1;
				end
			end
			wsd_pkg::PH_EXT: begin
				// big-endian; bit 63 of a 64-bit length falls off the top
				len_d = {len_q[54:0], rx_byte};
				if (ext_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					ext_d = ext_q - 3'd1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				if (kc_q == 2'd3) begin
					hdr_done = 1'b1;
				end else begin
					kc_d = kc_q + 2'd1;
				end
			end
			wsd_pkg::PH_DATA: begin
				emit                   = 1'b1;
				push_item.item_kind    = wsd_pkg::KindPayload;
				push_item.fin_bit      = fin_q;
				push_item.frame_opcode = op_q;
				push_item.is_masked    = masked_q;
				push_item.payload_len  = len_q;
				push_item.data_byte    = rx_byte ^ (masked_q ? kb : 8'd0);
				push_item.last         = data_last;
				kc_d                   = kc_q + 2'd1;
				if (left_q != 63'd0) begin
					left_d = left_q - 63'd1;
				end
				if (data_last) begin
					phase_d = wsd_pkg::PH_BYTE0;
				end
			end
			default: begin
				phase_d = wsd_pkg::PH_BYTE0;
			end
		endcase

		if (len_done) begin
			if (masked_d) begin
				kc_d    = 2'd0;
				key_d   = '0;
				phase_d = wsd_pkg::PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			emit                   = 1'b1;
			kc_d                   = 2'd0;
			left_d                 = len_d;
			push_item.item_kind    = wsd_pkg::KindHeader;
			push_item.fin_bit      = fin_d;
			push_item.frame_opcode = op_d;
			push_item.is_masked    = masked_d;
			push_item.payload_len  = len_d;
			push_item.oversize     = (len_d[62:16] != 47'd0) || (len_d[15:0] > max_payload);
			push_item.last         = (len_d == 63'd0);
			phase_d = (len_d == 63'd0) ? wsd_pkg::PH_BYTE0 : wsd_pkg::PH_DATA;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_BYTE0;
			ext_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			kc_q     <= '0;
			left_q   <= '0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			masked_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			ext_q    <= ext_d;
			len_q    <= len_d;
			key_q    <= key_d;
			kc_q     <= kc_d;
			left_q   <= left_d;
			fin_q    <= fin_d;
			op_q     <= op_d;
			masked_q <= masked_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/wsd_queue.sv =====
// Short result queue between the parser and the output stage.
`default_nettype none

module wsd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wsd_pkg::res_t     push_item,
	input  wire logic              pop,
	output wsd_pkg::res_t          head,
	output wsd_pkg::q_stat_t       stat
);

	wsd_pkg::res_t               entry_q [wsd_pkg::QDepth];
	logic [wsd_pkg::QAw-1:0]     wr_ptr_q;
	logic [wsd_pkg::QAw-1:0]     rd_ptr_q;
	logic [wsd_pkg::QAw:0]       count_q;

	assign stat.full  = (count_q == (wsd_pkg::QAw+1)'(wsd_pkg::QDepth));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/wsd_back.sv =====
// Back end: output register that drains the result queue.
`default_nettype none

module wsd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wsd_pkg::q_stat_t  stat,
	input  wire wsd_pkg::res_t     head,
	input  wire logic              res_stall,
	output logic                   pop,
	output logic                   res_valid,
	output wsd_pkg::res_t          res_item
);

	logic          valid_q;
	wsd_pkg::res_t item_q;

	// refill when the register is empty or being taken this cycle
	assign pop       = !stat.empty && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign res_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !res_stall) begin
			valid_q <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

endmodule

`default_nettype wire

// ===== sv/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser, result queue, output stage.
//
//  channel  | signals                              | direction | moves
//  ---------+--------------------------------------+-----------+--------------------------
//  rx       | rx_valid, rx_stall, rx_byte          | in        | one stream byte per item
//  res      | res_valid, res_stall, result fields  | out       | header or payload item
//  config   | psel, penable, pwrite, paddr, ...    | in        | max_payload at address 0
//
// One byte is taken every cycle while rx_stall is low. Each result is written into the
// four-entry queue at the edge that takes its byte; the output stage takes it from there.
// rx_stall rises only when the queue holds four items, so res_stall backs up into rx
// after the queue fills. Reset clears the parser to wait for a first header byte and
// sets max_payload to 4096; there is no clearing pass.
`default_nettype none

module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte stream in
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	// results out
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             item_kind,
	output logic             fin_bit,
	output logic [3:0]       frame_opcode,
	output logic             is_masked,
	output logic [62:0]      payload_len,
	output logic             oversize,
	output logic [7:0]       data_byte,
	output logic             last,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0]       max_payload_q;
	logic              accept;
	logic              push;
	logic              pop;
	wsd_pkg::res_t     push_item;
	wsd_pkg::res_t     head;
	wsd_pkg::res_t     res_item;
	wsd_pkg::q_stat_t  stat;
	logic              reg_idx;

	// register file: a single word, index from the word address
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata  = (reg_idx == wsd_pkg::RegMaxPayload) ? {16'd0, max_payload_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= wsd_pkg::MaxPayloadReset;
		end else if (psel && penable && pwrite && pready
		             && (reg_idx == wsd_pkg::RegMaxPayload)) begin
			max_payload_q <= pwdata[15:0];
		end
	end

	// front stalls only on a full queue
	assign rx_stall = stat.full;
	assign accept   = rx_valid && !rx_stall;

	wsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.max_payload (max_payload_q),
		.push        (push),
		.push_item   (push_item)
	);

	wsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.head      (head),
		.res_stall (res_stall),
		.pop       (pop),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	assign item_kind    = res_item.item_kind;
	assign fin_bit      = res_item.fin_bit;
	assign frame_opcode = res_item.frame_opcode;
	assign is_masked    = res_item.is_masked;
	assign payload_len  = res_item.payload_len;
	assign oversize     = res_item.oversize;
	assign data_byte    = res_item.data_byte;
	assign last         = res_item.last;

endmodule

`default_nettype wire

// ===== sv/wsd_checker.sv =====
// Port-level checks on the deframer's result channel, bound to the top level.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"

module wsd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_valid,
	input  wire logic        res_stall,
	input  wire logic        item_kind,
	input  wire logic [62:0] payload_len,
	input  wire logic        oversize,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last
);

	`WSD_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(data_byte) && $stable(payload_len) && $stable(item_kind), "result changed while stalled")
	`WSD_ASSERT_NOW(a_hdr_last_len, clk, arst_n, res_valid && (item_kind == wsd_pkg::KindHeader), last == (payload_len == 63'd0), "header last flag disagrees with length")
	`WSD_ASSERT_NOW(a_hdr_no_data, clk, arst_n, res_valid && (item_kind == wsd_pkg::KindHeader), data_byte == 8'd0, "header result carries data")
	`WSD_ASSERT_NOW(a_pay_no_over, clk, arst_n, res_valid && (item_kind == wsd_pkg::KindPayload), !oversize && (payload_len != 63'd0), "payload result with bad header fields")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.item_kind   (item_kind),
	.payload_len (payload_len),
	.oversize    (oversize),
	.data_byte   (data_byte),
	.last        (last)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the WebSocket frame deframer: frame stimulus, predictor, checks.
`timescale 1ns / 1ps

module testbench;

	// Register map: max_payload is register 0, so byte address 0. Address 4 holds no register.
	localparam logic [2:0] AddrMaxPayload = {1'b0, wsd_pkg::RegMaxPayload, 2'b00};
	localparam logic [2:0] AddrSpare      = 3'd4;

	// Length forms of the second header byte.
	localparam int FormShort = 0;
	localparam int FormExt16 = 1;
	localparam int FormExt64 = 2;

	localparam int CycleLimit = 200000;

	// Tracks the parser state byte by byte and keeps the results still owed by the block.
	class deframe_tracker;
		logic [15:0]      limit;
		wsd_pkg::phase_t  stage;
		logic [2:0]       ext_left;
		logic [63:0]      len_acc;
		logic [31:0]      key;
		logic [1:0]       key_idx;
		logic [62:0]      remaining;
		logic             fin;
		logic             masked;
		logic [3:0]       opcode;
		wsd_pkg::res_t    pending_items[$];
		int               mismatches;
		int               checked;

		function new();
			limit      = wsd_pkg::MaxPayloadReset;
			stage      = wsd_pkg::PH_BYTE0;
			ext_left   = '0;
			len_acc    = '0;
			key        = '0;
			key_idx    = '0;
			remaining  = '0;
			fin        = 1'b0;
			masked     = 1'b0;
			opcode     = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			mismatches++;
		endtask

		function void write_reg(logic [2:0] addr, logic [31:0] data);
			if (addr == AddrMaxPayload) begin
				limit = data[15:0];
			end
		endfunction

		function wsd_pkg::res_t frame_fields(logic kind);
			wsd_pkg::res_t r;
			r              = '0;
			r.item_kind    = kind;
			r.fin_bit      = fin;
			r.frame_opcode = opcode;
			r.is_masked    = masked;
			r.payload_len  = len_acc[62:0];
			return r;
		endfunction

		function void finish_header();
			wsd_pkg::res_t r;
			len_acc[63] = 1'b0;
			r           = frame_fields(wsd_pkg::KindHeader);
			r.oversize  = (len_acc[62:0] > 63'(limit));
			key_idx     = '0;
			remaining   = len_acc[62:0];
			if (remaining == '0) begin
				r.last = 1'b1;
				stage  = wsd_pkg::PH_BYTE0;
			end else begin
				stage = wsd_pkg::PH_DATA;
			end
			pending_items.push_back(r);
		endfunction

		function void finish_length();
			if (masked) begin
				key_idx = '0;
				key     = '0;
				stage   = wsd_pkg::PH_KEY;
			end else begin
				finish_header();
			end
		endfunction

		function void take_byte(logic [7:0] b);
			wsd_pkg::res_t r;
			logic [7:0]    kb;
			unique case (stage)
				wsd_pkg::PH_BYTE0: begin
					fin    = b[7];
					opcode = b[3:0];
					stage  = wsd_pkg::PH_BYTE1;
				end
				wsd_pkg::PH_BYTE1: begin
					masked  = b[7];
					key     = '0;
					len_acc = '0;
					if (b[6:0] == wsd_pkg::Len16Code) begin
						ext_left = wsd_pkg::Ext16Bytes;
						stage    = wsd_pkg::PH_EXT;
					end else if (b[6:0] == wsd_pkg::Len64Code) begin
						ext_left = wsd_pkg::Ext64Bytes;
						stage    = wsd_pkg::PH_EXT;
					end else begin
						len_acc = 64'(b[6:0]);
						finish_length();
					end
				end
				wsd_pkg::PH_EXT: begin
					len_acc = {len_acc[55:0], b};
					if (ext_left == '0) begin
						finish_length();
					end else begin
						ext_left = ext_left - 3'd1;
					end
				end
				wsd_pkg::PH_KEY: begin
					key = {key[23:0], b};
					if (key_idx == 2'd3) begin
						finish_header();
					end else begin
						key_idx = key_idx + 2'd1;
					end
				end
				wsd_pkg::PH_DATA: begin
					kb          = masked ? key[31 - 8 * key_idx -: 8] : 8'h00;
					r           = frame_fields(wsd_pkg::KindPayload);
					r.data_byte = b ^ kb;
					key_idx     = key_idx + 2'd1;
					if (remaining != '0) begin
						remaining = remaining - 63'd1;
					end
					if (remaining == '0) begin
						r.last = 1'b1;
						stage  = wsd_pkg::PH_BYTE0;
					end
					pending_items.push_back(r);
				end
				default: stage = wsd_pkg::PH_BYTE0;
			endcase
		endfunction

		task check_result(wsd_pkg::res_t got);
			wsd_pkg::res_t want;
			string         bad;
			if (pending_items.size() == 0) begin
				report($sformatf("result with nothing expected: %p", got));
				return;
			end
			want = pending_items.pop_front();
			bad  = "";
			if (got.item_kind    !== want.item_kind)    bad = {bad, " item_kind"};
			if (got.fin_bit      !== want.fin_bit)      bad = {bad, " fin_bit"};
			if (got.frame_opcode !== want.frame_opcode) bad = {bad, " frame_opcode"};
			if (got.is_masked    !== want.is_masked)    bad = {bad, " is_masked"};
			if (got.payload_len  !== want.payload_len)  bad = {bad, " payload_len"};
			if (got.oversize     !== want.oversize)     bad = {bad, " oversize"};
			if (got.data_byte    !== want.data_byte)    bad = {bad, " data_byte"};
			if (got.last         !== want.last)         bad = {bad, " last"};
			if (bad != "") begin
				report($sformatf("item %0d:%s got %p want %p", checked, bad, got, want));
			end
			checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_stall;
	logic [7:0]  rx_byte;
	logic        res_valid;
	logic        res_stall;
	logic        item_kind;
	logic        fin_bit;
	logic [3:0]  frame_opcode;
	logic        is_masked;
	logic [62:0] payload_len;
	logic        oversize;
	logic [7:0]  data_byte;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	deframe_tracker tracker = new();

	// Idle odds in percent for each side; hold_cycles forces a long receiver stall.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;
	int bytes_sent    = 0;
	int cycle_count   = 0;

	websocket_frame_deframer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.item_kind    (item_kind),
		.fin_bit      (fin_bit),
		.frame_opcode (frame_opcode),
		.is_masked    (is_masked),
		.payload_len  (payload_len),
		.oversize     (oversize),
		.data_byte    (data_byte),
		.last         (last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stall per cycle, or a forced hold-off counted down here.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_stall <= 1'b1;
			hold_cycles--;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Result monitor: every accepted result goes to the tracker.
	always @(posedge clk) begin
		wsd_pkg::res_t seen;
		if (arst_n && res_valid && !res_stall) begin
			seen.item_kind    = item_kind;
			seen.fin_bit      = fin_bit;
			seen.frame_opcode = frame_opcode;
			seen.is_masked    = is_masked;
			seen.payload_len  = payload_len;
			seen.oversize     = oversize;
			seen.data_byte    = data_byte;
			seen.last         = last;
			tracker.check_result(seen);
		end
	end

	// Offer one stream byte, with random idle cycles ahead of it; the tracker
	// sees the byte at the edge where the block takes it.
	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall);
		tracker.take_byte(b);
		bytes_sent++;
	endtask

	// One frame: header in the chosen length form, key when masked, then up to
	// data_cap random payload bytes. Bit 63 of a 64-bit length rides along.
	task automatic send_frame(input logic [7:0] first, input logic masked, input int form,
			input logic [63:0] length, input int data_cap);
		logic [63:0] count;
		push_byte(first);
		case (form)
			FormExt16: begin
				push_byte({masked, wsd_pkg::Len16Code});
				push_byte(length[15:8]);
				push_byte(length[7:0]);
				count = 64'(length[15:0]);
			end
			FormExt64: begin
				push_byte({masked, wsd_pkg::Len64Code});
				for (int i = 7; i >= 0; i--) begin
					push_byte(length[8 * i +: 8]);
				end
				count = {1'b0, length[62:0]};
			end
			default: begin
				push_byte({masked, length[6:0]});
				count = 64'(length[6:0]);
			end
		endcase
		if (masked) begin
			repeat (4) push_byte(8'($urandom));
		end
		for (int k = 0; k < data_cap && 64'(k) < count; k++) begin
			push_byte(8'($urandom));
		end
	endtask

	// Random frame: mostly short lengths so many headers go by; 16- and 64-bit
	// forms include non-minimal encodings and a random top length bit.
	task automatic random_frame();
		int          pick;
		int          form;
		logic [63:0] length;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			form = FormShort;
			pick = $urandom_range(0, 9);
			if (pick < 6)      length = 64'($urandom_range(0, 8));
			else if (pick < 9) length = 64'($urandom_range(9, 40));
			else               length = 64'($urandom_range(41, 125));
		end else if (pick < 85) begin
			form   = FormExt16;
			length = ($urandom_range(0, 9) < 8) ? 64'($urandom_range(0, 40))
				: 64'($urandom_range(41, 300));
		end else begin
			form   = FormExt64;
			length = {1'($urandom), 55'd0, 8'($urandom_range(0, 60))};
		end
		send_frame(8'($urandom), 1'($urandom), form, length, 1000);
	endtask

	task automatic random_frames(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			random_frame();
		end
	endtask

	// Sender stays quiet until every owed result is out, then idles on so that
	// nothing is left in flight.
	task automatic drain();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (tracker.pending_items.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(addr, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Read max_payload back and compare with the tracker's copy.
	task automatic check_limit();
		logic [31:0] data;
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= AddrMaxPayload;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (data[15:0] !== tracker.limit) begin
			tracker.report($sformatf("max_payload reads %h, want %h", data[15:0], tracker.limit));
		end
	endtask

	// Limit write with junk in the upper half, then a write to the empty address
	// that must leave the limit alone.
	task automatic set_limit(input logic [15:0] value);
		apb_write(AddrMaxPayload, {16'($urandom), value});
		apb_write(AddrSpare, $urandom);
		check_limit();
	endtask

	initial begin
		arst_n    = 1'b0;
		rx_valid  = 1'b0;
		rx_byte   = '0;
		res_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset limit of 4096.
		check_limit();
		// empty unmasked frame, all-zero header bytes
		send_frame(8'h00, 1'b0, FormShort, 64'd0, 1000);
		// reserved bits and opcode all ones, masked, 16-bit form for a tiny length
		send_frame(8'hFF, 1'b1, FormExt16, 64'd2, 1000);
		// 64-bit form with the top length bit set: it is dropped, length stays 1
		send_frame(8'h8A, 1'b0, FormExt64, {1'b1, 63'd1}, 1000);
		drain();

		// Limit 0: every nonempty frame is flagged. Slow receiver.
		set_limit(16'h0000);
		send_idle_pct = 7;
		recv_idle_pct = 66;
		random_frames(560);
		drain();

		// Limit at its top. Slow sender.
		set_limit(16'hFFFF);
		send_idle_pct = 66;
		recv_idle_pct = 7;
		random_frames(560);
		drain();

		// Small limit so lengths land on both sides of it. Full rate both ways,
		// with one long receiver hold-off that backs the queue up into rx_stall,
		// and one pause of the sender until everything is out.
		set_limit(16'($urandom_range(10, 30)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_frames(200);
		hold_cycles = 300;
		random_frames(200);
		drain();
		random_frames(160);
		// All-ones 64-bit length: payload_len of all ones, never finished.
		send_frame(8'($urandom), 1'b1, FormExt64, 64'hFFFF_FFFF_FFFF_FFFF, 16);
		drain();

		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wsd_pkg.sv
sv/wsd_front.sv
sv/wsd_queue.sv
sv/wsd_back.sv
sv/websocket_frame_deframer.sv
sv/wsd_checker.sv
tb/testbench.sv
